@@ hw/rtl/rsch_pkg.sv @@
// ============================================================================
// rsch_pkg
// Shared constants for the ray/sphere closest hit block: field widths,
// request opcodes, fixed-point epsilon and internal datapath widths.
// ============================================================================
package rsch_pkg;

    // default table depth
    localparam int RSCH_MAX_SPHERES = 16;

    // port field widths
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    localparam int DIST_W  = 31;

    // request opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RAY   = 1'b1;

    // epsilon 0.001 in Q16.16 and saturated distance
    localparam logic [DIST_W-1:0] EPS_Q = 31'd66;
    localparam logic [DIST_W-1:0] T_SAT = 31'h7FFF_FFFF;

    // internal datapath widths
    localparam int OCW  = COORD_W + 1;   // origin minus center
    localparam int SUMW = 70;            // exact dot product sums
    localparam int AW   = 48;            // a = d.d in Q16.16
    localparam int HW   = 52;            // h and c, signed Q16.16
    localparam int MW   = 52;            // magnitudes for split multiply
    localparam int PH   = MW / 2;        // half of a split operand
    localparam int DSW  = 104;           // discriminant, Q32.32
    localparam int SQ   = 50;            // root bits, one per stage
    localparam int NW   = 54;            // root numerators, signed
    localparam int QB   = 31;            // quotient bits, one per stage
    localparam int RW   = 80;            // division remainder

endpackage

@@ hw/rtl/ray_sphere_closest_hit.sv @@
// With n = max(min(sphere_count, MAX_SPHERES), 1), each ray request issues n sphere tests; the ray
// result is registered once the last of them leaves the pipeline, and waits while the result side stalls.
// Throughput: one sphere test enters the intersection pipeline per cycle unless the result side stalls;
// the next request is accepted only once the last test of a ray has issued; write requests do not make it busy.
// The root (50 stages) and the two dividers (31 stages) set the pipeline depth.
// Reset (synchronous, active low) clears sphere_count, the issue sequencer and valid bits.
// ============================================================================
// ray_sphere_closest_hit
// Sphere table plus a deep intersection pipeline that tests one stored sphere
// per cycle, unless the result side stalls, and keeps the nearest hit of each ray.
// ============================================================================
module ray_sphere_closest_hit
    import rsch_pkg::*;
#(
    parameter int MAX_SPHERES = RSCH_MAX_SPHERES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_opcode,
    input  logic [SLOT_W-1:0]         i_slot,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_center_z,
    input  logic [RAD_W-1:0]          i_sphere_radius,
    input  logic signed [COORD_W-1:0] i_origin_x,
    input  logic signed [COORD_W-1:0] i_origin_y,
    input  logic signed [COORD_W-1:0] i_origin_z,
    input  logic signed [COORD_W-1:0] i_dir_x,
    input  logic signed [COORD_W-1:0] i_dir_y,
    input  logic signed [COORD_W-1:0] i_dir_z,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_hit,
    output logic [SLOT_W-1:0]         o_hit_index,
    output logic [DIST_W-1:0]         o_distance,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CNT_W-1:0]          i_cfg_data
);

    localparam int IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic             test;
        logic [IDX_W-1:0] idx;
    } t_tok;

    typedef struct packed {
        t_tok                    tok;
        logic                    miss;
        logic [AW-1:0]           a;
        logic signed [HW-1:0]    h;
        logic [DSW-1:0]          rem;
        logic [SQ-1:0]           root;
    } t_sq;

    typedef struct packed {
        t_tok                    tok;
        logic                    miss;
        logic [AW-1:0]           a;
        logic [1:0]              pos;
        logic [1:0]              sat;
        logic [1:0][RW-1:0]      rem;
        logic [1:0][QB-1:0]      q;
    } t_dv;

    logic ce;

    // configuration register
    logic [CNT_W-1:0] r_cfg_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= '0;
        end else if (i_cfg_we) begin
            r_cfg_count <= i_cfg_data;
        end
    end

    // sphere table
    logic signed [COORD_W-1:0] mem_cx [MAX_SPHERES];
    logic signed [COORD_W-1:0] mem_cy [MAX_SPHERES];
    logic signed [COORD_W-1:0] mem_cz [MAX_SPHERES];
    logic [RAD_W-1:0]          mem_r  [MAX_SPHERES];

    logic in_acc, wr_en, ray_acc;
    logic r_busy;

    assign o_in_ready = !r_busy;
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_en      = in_acc && (i_opcode == OP_WRITE) && (32'(i_slot) < 32'(MAX_SPHERES));
    assign ray_acc    = in_acc && (i_opcode == OP_RAY);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_cx[IDX_W'(i_slot)] <= i_center_x;
            mem_cy[IDX_W'(i_slot)] <= i_center_y;
            mem_cz[IDX_W'(i_slot)] <= i_center_z;
            mem_r[IDX_W'(i_slot)]  <= i_sphere_radius;
        end
    end

    // issue sequencer: held ray and sphere counter
    logic [IDX_W-1:0]          r_k, r_last_k;
    logic                      r_test;
    logic signed [COORD_W-1:0] r_ray_o [3];
    logic signed [COORD_W-1:0] r_ray_d [3];
    logic [IDX_W-1:0]          n_last_k;
    logic                      n_test;
    t_tok                      issue_tok;

    always_comb begin
        int cnt;
        cnt = int'(r_cfg_count);
        if (cnt > MAX_SPHERES) begin
            cnt = MAX_SPHERES;
        end
        n_test   = (cnt != 0);
        n_last_k = IDX_W'(cnt - 1);
    end

    always_comb begin
        issue_tok.vld   = r_busy;
        issue_tok.first = (r_k == '0);
        issue_tok.last  = (r_k == r_last_k) || !r_test;
        issue_tok.test  = r_test;
        issue_tok.idx   = r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (ray_acc) begin
            r_busy   <= 1'b1;
            r_k      <= '0;
            r_last_k <= n_last_k;
            r_test   <= n_test;
            r_ray_o  <= '{i_origin_x, i_origin_y, i_origin_z};
            r_ray_d  <= '{i_dir_x, i_dir_y, i_dir_z};
        end else if (r_busy && ce) begin
            if (issue_tok.last) begin
                r_busy <= 1'b0;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // stage 1: table read
    t_tok                      r_s1_tok;
    logic signed [COORD_W-1:0] r_s1_c [3];
    logic [RAD_W-1:0]          r_s1_r;
    logic signed [COORD_W-1:0] r_s1_o [3];
    logic signed [COORD_W-1:0] r_s1_d [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tok <= '0;
        end else if (ce) begin
            r_s1_tok <= issue_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s1_c <= '{mem_cx[r_k], mem_cy[r_k], mem_cz[r_k]};
            r_s1_r <= mem_r[r_k];
            r_s1_o <= r_ray_o;
            r_s1_d <= r_ray_d;
        end
    end

    // stage 2: origin minus center
    t_tok                  r_s2_tok;
    logic signed [OCW-1:0] r_s2_oc [3];
    logic signed [COORD_W-1:0] r_s2_d [3];
    logic [RAD_W-1:0]      r_s2_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_tok <= '0;
        end else if (ce) begin
            r_s2_tok <= r_s1_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_oc[i] <= OCW'(r_s1_o[i]) - OCW'(r_s1_c[i]);
            end
            r_s2_d <= r_s1_d;
            r_s2_r <= r_s1_r;
        end
    end

    // stage 3: exact products
    t_tok                   r_s3_tok;
    logic signed [OCW+COORD_W-1:0] r_s3_ocd [3];
    logic [2*OCW-1:0]       r_s3_oc2 [3];
    logic [2*COORD_W-1:0]   r_s3_dd  [3];
    logic [2*RAD_W-1:0]     r_s3_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_tok <= '0;
        end else if (ce) begin
            r_s3_tok <= r_s2_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_ocd[i] <= (OCW+COORD_W)'(r_s2_oc[i]) * (OCW+COORD_W)'(r_s2_d[i]);
                r_s3_oc2[i] <= (2*OCW)'(r_s2_oc[i]) * (2*OCW)'(r_s2_oc[i]);
                r_s3_dd[i]  <= (2*COORD_W)'(r_s2_d[i]) * (2*COORD_W)'(r_s2_d[i]);
            end
            r_s3_rr <= (2*RAD_W)'(r_s2_r) * (2*RAD_W)'(r_s2_r);
        end
    end

    // stage 4: quadratic coefficients, floored to Q16.16
    t_tok                 r_s4_tok;
    logic [AW-1:0]        r_s4_a;
    logic signed [HW-1:0] r_s4_h, r_s4_c;
    logic [2*COORD_W-1:0] asum;
    logic signed [SUMW-1:0] hsum, csum;

    always_comb begin
        asum = r_s3_dd[0] + r_s3_dd[1] + r_s3_dd[2];
        hsum = SUMW'(r_s3_ocd[0]) + SUMW'(r_s3_ocd[1]) + SUMW'(r_s3_ocd[2]);
        csum = SUMW'(r_s3_oc2[0]) + SUMW'(r_s3_oc2[1]) + SUMW'(r_s3_oc2[2])
             - SUMW'(r_s3_rr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_tok <= '0;
        end else if (ce) begin
            r_s4_tok <= r_s3_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s4_a <= asum[16 +: AW];
            r_s4_h <= hsum[16 +: HW];
            r_s4_c <= csum[16 +: HW];
        end
    end

    // stage 5: split partial products for h*h and a*|c|
    t_tok                 r_s5_tok;
    logic [AW-1:0]        r_s5_a;
    logic signed [HW-1:0] r_s5_h;
    logic                 r_s5_cpos, r_s5_miss;
    logic [2*PH-1:0]      r_s5_hhh, r_s5_hhl, r_s5_hll;
    logic [2*PH-1:0]      r_s5_ahh, r_s5_ahl, r_s5_alh, r_s5_all;
    logic [MW-1:0]        hmag, cmag, amag;

    always_comb begin
        hmag = r_s4_h[HW-1] ? MW'(-r_s4_h) : MW'(r_s4_h);
        cmag = r_s4_c[HW-1] ? MW'(-r_s4_c) : MW'(r_s4_c);
        amag = MW'(r_s4_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_tok <= '0;
        end else if (ce) begin
            r_s5_tok <= r_s4_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s5_a    <= r_s4_a;
            r_s5_h    <= r_s4_h;
            r_s5_cpos <= !r_s4_c[HW-1] && (r_s4_c != '0);
            r_s5_miss <= (r_s4_a == '0);
            r_s5_hhh  <= (2*PH)'(hmag[MW-1:PH]) * (2*PH)'(hmag[MW-1:PH]);
            r_s5_hhl  <= (2*PH)'(hmag[MW-1:PH]) * (2*PH)'(hmag[PH-1:0]);
            r_s5_hll  <= (2*PH)'(hmag[PH-1:0])  * (2*PH)'(hmag[PH-1:0]);
            r_s5_ahh  <= (2*PH)'(amag[MW-1:PH]) * (2*PH)'(cmag[MW-1:PH]);
            r_s5_ahl  <= (2*PH)'(amag[MW-1:PH]) * (2*PH)'(cmag[PH-1:0]);
            r_s5_alh  <= (2*PH)'(amag[PH-1:0])  * (2*PH)'(cmag[MW-1:PH]);
            r_s5_all  <= (2*PH)'(amag[PH-1:0])  * (2*PH)'(cmag[PH-1:0]);
        end
    end

    // stage 6: combine partial products
    t_tok                 r_s6_tok;
    logic [AW-1:0]        r_s6_a;
    logic signed [HW-1:0] r_s6_h;
    logic                 r_s6_cpos, r_s6_miss;
    logic [DSW-1:0]       r_s6_h2, r_s6_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_tok <= '0;
        end else if (ce) begin
            r_s6_tok <= r_s5_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s6_a    <= r_s5_a;
            r_s6_h    <= r_s5_h;
            r_s6_cpos <= r_s5_cpos;
            r_s6_miss <= r_s5_miss;
            r_s6_h2   <= (DSW'(r_s5_hhh) << (2*PH)) + (DSW'(r_s5_hhl) << (PH+1))
                       + DSW'(r_s5_hll);
            r_s6_ac   <= (DSW'(r_s5_ahh) << (2*PH))
                       + ((DSW'(r_s5_ahl) + DSW'(r_s5_alh)) << PH) + DSW'(r_s5_all);
        end
    end

    // discriminant into the root chain
    t_sq r_sq [SQ+1];
    t_sq n_sq [SQ+1];

    always_comb begin
        n_sq[0].tok  = r_s6_tok;
        n_sq[0].a    = r_s6_a;
        n_sq[0].h    = r_s6_h;
        n_sq[0].root = '0;
        n_sq[0].miss = r_s6_miss || (r_s6_cpos && (r_s6_h2 < r_s6_ac));
        n_sq[0].rem  = r_s6_cpos ? (r_s6_h2 - r_s6_ac) : (r_s6_h2 + r_s6_ac);
    end

    // bitwise square root, one result bit per stage
    for (genvar gi = 0; gi <= SQ; gi++) begin : g_sq
        if (gi > 0) begin : g_step
            localparam int B = SQ - gi;
            logic [DSW-1:0] trial;
            always_comb begin
                trial = (DSW'(r_sq[gi-1].root) << (B+1)) + (DSW'(1) << (2*B));
                n_sq[gi] = r_sq[gi-1];
                if (r_sq[gi-1].rem >= trial) begin
                    n_sq[gi].rem     = r_sq[gi-1].rem - trial;
                    n_sq[gi].root[B] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[gi].tok <= '0;
            end else if (ce) begin
                r_sq[gi] <= n_sq[gi];
            end
        end
    end

    // root numerators: -h - s and -h + s
    t_tok                 r_nr_tok;
    logic                 r_nr_miss;
    logic [AW-1:0]        r_nr_a;
    logic signed [NW-1:0] r_nr_n [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nr_tok <= '0;
        end else if (ce) begin
            r_nr_tok <= r_sq[SQ].tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_nr_miss <= r_sq[SQ].miss;
            r_nr_a    <= r_sq[SQ].a;
            r_nr_n[0] <= -NW'(r_sq[SQ].h) - NW'(r_sq[SQ].root);
            r_nr_n[1] <= -NW'(r_sq[SQ].h) + NW'(r_sq[SQ].root);
        end
    end

    // divider setup: sign, saturation and initial remainder
    t_dv r_dv [QB+1];
    t_dv n_dv [QB+1];

    always_comb begin
        n_dv[0].tok  = r_nr_tok;
        n_dv[0].miss = r_nr_miss;
        n_dv[0].a    = r_nr_a;
        n_dv[0].q    = '0;
        for (int i = 0; i < 2; i++) begin
            n_dv[0].pos[i] = !r_nr_n[i][NW-1] && (r_nr_n[i] != '0);
            n_dv[0].sat[i] = n_dv[0].pos[i]
                && (64'(r_nr_n[i][NW-2:0]) >= (64'(r_nr_a) << 15));
            n_dv[0].rem[i] = n_dv[0].pos[i] ? (RW'(r_nr_n[i][NW-2:0]) << 16) : '0;
        end
    end

    // restoring division, one quotient bit per stage for both roots
    for (genvar gj = 0; gj <= QB; gj++) begin : g_dv
        if (gj > 0) begin : g_step
            localparam int J = QB - gj;
            logic [RW-1:0] dv;
            always_comb begin
                dv = RW'(r_dv[gj-1].a) << J;
                n_dv[gj] = r_dv[gj-1];
                for (int i = 0; i < 2; i++) begin
                    if (r_dv[gj-1].rem[i] >= dv) begin
                        n_dv[gj].rem[i]  = r_dv[gj-1].rem[i] - dv;
                        n_dv[gj].q[i][J] = 1'b1;
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[gj].tok <= '0;
            end else if (ce) begin
                r_dv[gj] <= n_dv[gj];
            end
        end
    end

    // root selection and nearest-hit tracking
    t_tok              tail_tok;
    logic [DIST_W-1:0] t_root [2];
    logic [DIST_W-1:0] cand_t;
    logic              cand_hit;
    logic              r_found;
    logic [DIST_W-1:0] r_best_t;
    logic [IDX_W-1:0]  r_best_k;
    logic              n_found;
    logic [DIST_W-1:0] n_best_t;
    logic [IDX_W-1:0]  n_best_k;

    assign tail_tok = r_dv[QB].tok;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            if (r_dv[QB].sat[i]) begin
                t_root[i] = T_SAT;
            end else if (r_dv[QB].pos[i]) begin
                t_root[i] = r_dv[QB].q[i];
            end else begin
                t_root[i] = '0;
            end
        end
        cand_t   = (t_root[0] > EPS_Q) ? t_root[0] : t_root[1];
        cand_hit = tail_tok.test && !r_dv[QB].miss && (cand_t > EPS_Q);

        n_found  = r_found;
        n_best_t = r_best_t;
        n_best_k = r_best_k;
        if (tail_tok.first) begin
            n_found  = cand_hit;
            n_best_t = cand_t;
            n_best_k = tail_tok.idx;
        end else if (cand_hit && (!r_found || (cand_t < r_best_t))) begin
            n_found  = 1'b1;
            n_best_t = cand_t;
            n_best_k = tail_tok.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (ce && tail_tok.vld) begin
            r_found  <= n_found;
            r_best_t <= n_best_t;
            r_best_k <= n_best_k;
        end
    end

    // output register
    logic              r_out_valid;
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_index;
    logic [DIST_W-1:0] r_distance;

    assign ce = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            if (tail_tok.vld && tail_tok.last) begin
                r_out_valid <= 1'b1;
                r_hit       <= n_found;
                r_hit_index <= n_found ? SLOT_W'(n_best_k) : '0;
                r_distance  <= n_found ? n_best_t : T_SAT;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_hit_index = r_hit_index;
    assign o_distance  = r_distance;

endmodule
